// ===== src/grid_mirror_flip_defines.svh =====
// Assertion macros shared by the grid mirror flip block.
`ifndef GRID_MIRROR_FLIP_DEFINES_SVH
`define GRID_MIRROR_FLIP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define GMF_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define GMF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/gmf_pkg.sv =====
// Package for the grid mirror flip block: widths, codes, command and config types.
package gmf_pkg;

  localparam int unsigned MAX_CELLS_DEF = 65536;
  localparam int unsigned Q_DEPTH       = 4;
  localparam int          DIM_W         = 17;
  localparam int          CNT_W         = 16;
  localparam int          VAL_W         = 64;
  localparam int          IDX_W         = 3;

  typedef enum logic [IDX_W-1:0] {
    REG_NI          = 3'd0,
    REG_NJ          = 3'd1,
    REG_AXIS        = 3'd2,
    REG_FLIP        = 3'd3,
    REG_I_NEG       = 3'd4,
    REG_J_POS       = 3'd5,
    REG_FIRST_COORD = 3'd6,
    REG_LAST_COORD  = 3'd7
  } reg_idx_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_OVERLOAD = 2'd1,
    STAT_EARLY    = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_ERROR = 2'd2
  } op_t;

  typedef struct packed {
    op_t     op;
    logic    last;
    status_t status;
  } cmd_t;

  typedef struct packed {
    logic [DIM_W-1:0] ni;
    logic [DIM_W-1:0] nj;
    logic             axis_select;
    logic             flip_enable;
    logic             i_negative_flag;
    logic             j_positive_flag;
    logic [VAL_W-1:0] first_coord;
    logic [VAL_W-1:0] last_coord;
  } cfg_t;

endpackage

// ===== src/grid_mirror_flip.sv =====
// Grid mirror flip: loads a row-major ni x nj grid of 64-bit values into an on-chip
// memory, then drains it reversed along x (within rows) or y (row order) when enabled.
// Sustained rate is one item per clock in either direction while out_stall is low; the
// single-port grid memory, which takes one load write or one drain read per cycle, sets
// that figure. A drain result passes through the queue slot, the memory read register
// and the output register; loads that succeed give no result. Grid capacity is MAX_CELLS
// values. Unloaded memory entries are never read, so the memory needs no clearing pass.
`include "grid_mirror_flip_defines.svh"

module grid_mirror_flip import gmf_pkg::*; #(
  parameter int unsigned MAX_CELLS = MAX_CELLS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [VAL_W-1:0] cfg_wdata,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             in_req_type,
  input  logic [VAL_W-1:0] in_grid_value,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [VAL_W-1:0] out_value,
  output logic             out_last,
  output logic [1:0]       out_status,
  output logic             out_new_i_negative,
  output logic             out_new_j_positive,
  output logic [VAL_W-1:0] out_new_first_coord,
  output logic [VAL_W-1:0] out_new_last_coord
);

  localparam int AW   = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
  localparam int CW   = $clog2(MAX_CELLS + 1);
  localparam int PW   = 2 * DIM_W;
  localparam int QW   = $bits(cmd_t) + AW + VAL_W;

  cfg_t          cfg_r, cfg_nxt;
  logic [CW-1:0] cells_clip_r, cells_clip_nxt;
  logic          cells_ok_r, cells_ok_nxt;
  logic [PW-1:0] prod;
  logic          geom_clr;

  logic             q_push;
  cmd_t             push_cmd;
  logic [AW-1:0]    push_addr;
  logic [VAL_W-1:0] push_data;
  logic             q_full;
  logic             q_empty;
  logic             q_pop;
  logic [QW-1:0]    q_rd_data;
  cmd_t             q_cmd;
  logic [AW-1:0]    q_addr;
  logic [VAL_W-1:0] q_data;

  assign geom_clr = cfg_we && (cfg_index == REG_NI || cfg_index == REG_NJ);

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_NI:          cfg_nxt.ni              = cfg_wdata[DIM_W-1:0];
        REG_NJ:          cfg_nxt.nj              = cfg_wdata[DIM_W-1:0];
        REG_AXIS:        cfg_nxt.axis_select     = cfg_wdata[0];
        REG_FLIP:        cfg_nxt.flip_enable     = cfg_wdata[0];
        REG_I_NEG:       cfg_nxt.i_negative_flag = cfg_wdata[0];
        REG_J_POS:       cfg_nxt.j_positive_flag = cfg_wdata[0];
        REG_FIRST_COORD: cfg_nxt.first_coord     = cfg_wdata;
        REG_LAST_COORD:  cfg_nxt.last_coord      = cfg_wdata;
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  // Cell count, clipped to capacity, registered with the geometry.
  assign prod           = PW'(cfg_nxt.ni) * PW'(cfg_nxt.nj);
  assign cells_ok_nxt   = (prod != '0) && (prod <= PW'(MAX_CELLS));
  assign cells_clip_nxt = (prod > PW'(MAX_CELLS)) ? CW'(MAX_CELLS) : prod[CW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ni              <= DIM_W'(1);
      cfg_r.nj              <= DIM_W'(1);
      cfg_r.axis_select     <= 1'b0;
      cfg_r.flip_enable     <= 1'b0;
      cfg_r.i_negative_flag <= 1'b0;
      cfg_r.j_positive_flag <= 1'b0;
      cfg_r.first_coord     <= '0;
      cfg_r.last_coord      <= '0;
      cells_clip_r          <= CW'(1);
      cells_ok_r            <= 1'b1;
    end else begin
      cfg_r        <= cfg_nxt;
      cells_clip_r <= cells_clip_nxt;
      cells_ok_r   <= cells_ok_nxt;
    end
  end

  gmf_front #(
    .AW (AW),
    .CW (CW)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_req_type   (in_req_type),
    .in_grid_value (in_grid_value),
    .cfg           (cfg_r),
    .cells_clip    (cells_clip_r),
    .cells_ok      (cells_ok_r),
    .geom_clr      (geom_clr),
    .q_full        (q_full),
    .push          (q_push),
    .push_cmd      (push_cmd),
    .push_addr     (push_addr),
    .push_data     (push_data)
  );

  gmf_fifo #(
    .W     (QW),
    .DEPTH (Q_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_push),
    .wr_data ({push_cmd, push_addr, push_data}),
    .full    (q_full),
    .rd_en   (q_pop),
    .rd_data (q_rd_data),
    .empty   (q_empty)
  );

  assign q_cmd  = cmd_t'(q_rd_data[QW-1 -: $bits(cmd_t)]);
  assign q_addr = q_rd_data[VAL_W +: AW];
  assign q_data = q_rd_data[VAL_W-1:0];

  gmf_back #(
    .MAX_CELLS (MAX_CELLS),
    .AW        (AW)
  ) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_empty             (q_empty),
    .q_cmd               (q_cmd),
    .q_addr              (q_addr),
    .q_data              (q_data),
    .q_pop               (q_pop),
    .cfg                 (cfg_r),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_value           (out_value),
    .out_last            (out_last),
    .out_status          (out_status),
    .out_new_i_negative  (out_new_i_negative),
    .out_new_j_positive  (out_new_j_positive),
    .out_new_first_coord (out_new_first_coord),
    .out_new_last_coord  (out_new_last_coord)
  );

  `GMF_ASSERT(a_last_ok, out_valid && out_last, out_status == STAT_OK, "last marked on error")
  `GMF_ASSERT(a_err_zero, out_valid && out_status != STAT_OK, out_value == '0 && !out_last && out_new_first_coord == cfg_r.first_coord && out_new_i_negative == cfg_r.i_negative_flag, "error result not clean")
  `GMF_ASSERT_NEXT(a_q_hold, q_full && !q_pop, q_full, "queue lost an entry while blocked")

endmodule

// ===== src/gmf_fifo.sv =====
// Small command queue between the front and back parts.
module gmf_fifo import gmf_pkg::*; #(
  parameter int W     = 8,
  parameter int DEPTH = Q_DEPTH
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         wr_en,
  input  logic [W-1:0] wr_data,
  output logic         full,
  input  logic         rd_en,
  output logic [W-1:0] rd_data,
  output logic         empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  slot_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign rd_data = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (rd_en) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (wr_en && !rd_en) begin
      count_nxt = count_r + CW'(1);
    end else if (rd_en && !wr_en) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// ===== src/gmf_front.sv =====
// Front part: accepts items, tracks load and drain progress, issues memory commands.
module gmf_front import gmf_pkg::*; #(
  parameter int AW = 16,
  parameter int CW = 17
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             in_req_type,
  input  logic [VAL_W-1:0] in_grid_value,
  input  cfg_t             cfg,
  input  logic [CW-1:0]    cells_clip,
  input  logic             cells_ok,
  input  logic             geom_clr,
  input  logic             q_full,
  output logic             push,
  output cmd_t             push_cmd,
  output logic [AW-1:0]    push_addr,
  output logic [VAL_W-1:0] push_data
);

  logic [CW-1:0]    load_count_r, load_count_nxt;
  logic             load_error_r, load_error_nxt;
  logic [CNT_W-1:0] row_r, row_nxt;
  logic [CNT_W-1:0] col_r, col_nxt;
  logic [AW-1:0]    fwd_base_r, fwd_base_nxt;
  logic [AW-1:0]    rev_base_r, rev_base_nxt;

  logic [AW-1:0] ni_a;
  logic [AW-1:0] col_a;
  logic [AW-1:0] rev_cur;
  logic [AW-1:0] col_off;
  logic [AW-1:0] base;
  logic          x_flip;
  logic          y_flip;
  logic          is_last;
  logic          row_end;
  logic          full_load;

  assign in_stall  = q_full;
  assign push      = in_valid && !q_full;
  assign push_data = in_grid_value;

  assign x_flip    = cfg.flip_enable && !cfg.axis_select;
  assign y_flip    = cfg.flip_enable && cfg.axis_select;
  assign ni_a      = AW'(cfg.ni);
  assign col_a     = AW'(col_r);
  // Base of the mirrored row: first row starts at cells - ni, then steps back by ni.
  assign rev_cur   = (row_r == '0) ? (AW'(cells_clip) - ni_a) : rev_base_r;
  assign col_off   = x_flip ? (ni_a - AW'(1) - col_a) : col_a;
  assign base      = y_flip ? rev_cur : fwd_base_r;
  assign is_last   = ({1'b0, row_r} == (cfg.nj - DIM_W'(1)))
                  && ({1'b0, col_r} == (cfg.ni - DIM_W'(1)));
  assign row_end   = (({1'b0, col_r} + DIM_W'(1)) >= cfg.ni);
  assign full_load = (load_count_r >= cells_clip);

  always_comb begin
    load_count_nxt  = load_count_r;
    load_error_nxt  = load_error_r;
    row_nxt         = row_r;
    col_nxt         = col_r;
    fwd_base_nxt    = fwd_base_r;
    rev_base_nxt    = rev_base_r;
    push_cmd.op     = OP_ERROR;
    push_cmd.last   = 1'b0;
    push_cmd.status = STAT_OK;
    push_addr       = load_count_r[AW-1:0];

    if (!in_req_type) begin
      if (full_load) begin
        push_cmd.status = STAT_OVERLOAD;
        if (push) begin
          load_error_nxt = 1'b1;
        end
      end else begin
        push_cmd.op = OP_WRITE;
        if (push) begin
          load_count_nxt = load_count_r + CW'(1);
        end
      end
    end else if (load_error_r) begin
      push_cmd.status = STAT_OVERLOAD;
      if (push) begin
        load_count_nxt = '0;
        load_error_nxt = 1'b0;
        row_nxt        = '0;
        col_nxt        = '0;
        fwd_base_nxt   = '0;
      end
    end else if (!cells_ok || !full_load) begin
      push_cmd.status = STAT_EARLY;
    end else begin
      push_cmd.op   = OP_READ;
      push_cmd.last = is_last;
      push_addr     = base + col_off;
      if (push) begin
        if (is_last) begin
          load_count_nxt = '0;
          row_nxt        = '0;
          col_nxt        = '0;
          fwd_base_nxt   = '0;
        end else if (row_end) begin
          col_nxt      = '0;
          row_nxt      = row_r + CNT_W'(1);
          fwd_base_nxt = fwd_base_r + ni_a;
          rev_base_nxt = rev_cur - ni_a;
        end else begin
          col_nxt = col_r + CNT_W'(1);
        end
      end
    end

    if (geom_clr) begin
      load_count_nxt = '0;
      load_error_nxt = 1'b0;
      row_nxt        = '0;
      col_nxt        = '0;
      fwd_base_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_count_r <= '0;
      load_error_r <= 1'b0;
      row_r        <= '0;
      col_r        <= '0;
      fwd_base_r   <= '0;
    end else begin
      load_count_r <= load_count_nxt;
      load_error_r <= load_error_nxt;
      row_r        <= row_nxt;
      col_r        <= col_nxt;
      fwd_base_r   <= fwd_base_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rev_base_r <= rev_base_nxt;
  end

endmodule

// ===== src/gmf_back.sv =====
// Back part: grid memory, read stage and result output register.
module gmf_back import gmf_pkg::*; #(
  parameter int unsigned MAX_CELLS = MAX_CELLS_DEF,
  parameter int          AW        = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_empty,
  input  cmd_t             q_cmd,
  input  logic [AW-1:0]    q_addr,
  input  logic [VAL_W-1:0] q_data,
  output logic             q_pop,
  input  cfg_t             cfg,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [VAL_W-1:0] out_value,
  output logic             out_last,
  output logic [1:0]       out_status,
  output logic             out_new_i_negative,
  output logic             out_new_j_positive,
  output logic [VAL_W-1:0] out_new_first_coord,
  output logic [VAL_W-1:0] out_new_last_coord
);

  logic [VAL_W-1:0] grid_mem_r [MAX_CELLS];
  logic [VAL_W-1:0] rd_r;
  logic             s1_v_r, s1_v_nxt;
  cmd_t             s1_cmd_r;
  logic             out_valid_r, out_valid_nxt;

  logic out_free;
  logic s1_adv;
  logic applied;
  logic is_rd;

  assign out_free  = !out_valid_r || !out_stall;
  assign s1_adv    = s1_v_r && out_free;
  assign q_pop     = !q_empty && (!s1_v_r || out_free);
  assign out_valid = out_valid_r;
  assign is_rd     = (s1_cmd_r.op == OP_READ);
  assign applied   = is_rd && cfg.flip_enable;

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (q_pop) begin
      s1_v_nxt = (q_cmd.op != OP_WRITE);
    end else if (s1_adv) begin
      s1_v_nxt = 1'b0;
    end
    out_valid_nxt = s1_adv ? 1'b1 : (out_free ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_v_r      <= s1_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_cmd.op == OP_WRITE) begin
      grid_mem_r[q_addr] <= q_data;
    end
    if (q_pop && q_cmd.op == OP_READ) begin
      rd_r <= grid_mem_r[q_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_cmd_r <= q_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_value           <= is_rd ? rd_r : '0;
      out_last            <= is_rd && s1_cmd_r.last;
      out_status          <= 2'(s1_cmd_r.status);
      out_new_i_negative  <= cfg.i_negative_flag ^ (applied && !cfg.axis_select);
      out_new_j_positive  <= cfg.j_positive_flag ^ (applied && cfg.axis_select);
      out_new_first_coord <= applied ? cfg.last_coord : cfg.first_coord;
      out_new_last_coord  <= applied ? cfg.first_coord : cfg.last_coord;
    end
  end

endmodule
